### rtl/bahp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character classes for the bearer header parser.
// No dependencies; every other file imports this package.
package bahp_pkg;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int POS_W  = 13;
	localparam int CNT_W  = 13;
	localparam int STAT_W = 3;
	localparam int IDX_W  = 3;

	// Header and token bounds
	localparam int MAX_HEADER_BYTES = 8192;
	localparam int TOKEN_LIMIT_MAX  = 4096;
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_HEADER_BYTES - 1);
	localparam logic [CNT_W-1:0] LIMIT_TOP = CNT_W'(TOKEN_LIMIT_MAX);
	localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(TOKEN_LIMIT_MAX + 1);
	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(4096);

	// Scheme length ("bearer")
	localparam logic [IDX_W-1:0] SCHEME_LEN = IDX_W'(6);
	localparam logic [IDX_W-1:0] SCHEME_TOP = IDX_W'(7);

	// Characters
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_EMPTY_HDR  = 3'd1,
		ST_BAD_SCHEME = 3'd2,
		ST_EMPTY_TOK  = 3'd3,
		ST_TOO_LONG   = 3'd4,
		ST_BAD_CHAR   = 3'd5
	} status_t;

	// One input word
	typedef struct packed {
		logic [BYTE_W-1:0] header_byte;
		logic              byte_present;
		logic              last_byte;
	} item_t;

	// One result word
	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  token_offset;
		logic [CNT_W-1:0]  token_length;
	} result_t;

	function automatic logic is_space_tab(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || (b == CH_TAB);
	endfunction

	function automatic logic is_ws(input logic [BYTE_W-1:0] b);
		return is_space_tab(b) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic logic is_token_char(input logic [BYTE_W-1:0] b);
		return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
			8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h2B, 8'h2F, 8'h3D});
	endfunction

	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
		return (b inside {[8'h41:8'h5A]}) ? (b + 8'h20) : b;
	endfunction

	// Expected scheme letter at each position
	function automatic logic [BYTE_W-1:0] scheme_letter(input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			3'd0: c = 8'h62; // b
			3'd1: c = 8'h65; // e
			3'd2: c = 8'h61; // a
			3'd3: c = 8'h72; // r
			3'd4: c = 8'h65; // e
			3'd5: c = 8'h72; // r
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### rtl/bahp_in_stage.sv
`timescale 1ns / 1ps
// Input register for the bearer header parser: holds one word until the parser takes it.
// Depends on bahp_pkg.
module bahp_in_stage import bahp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	// Take a new word when empty or when the held word moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload: load on accept only
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/bahp_parse_core.sv
`timescale 1ns / 1ps
// Parse state and per-byte update of the bearer header parser; forms the result on the final word.
// Depends on bahp_pkg.
module bahp_parse_core import bahp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  item_t            item_s1,
	input  logic [CNT_W-1:0] limit,
	output logic             res_fire,
	output result_t          res
);

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SCHEME,
		PH_SCHEME_CRLF,
		PH_SEPARATED,
		PH_TOKEN
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic             mis_q, mis_n;
	logic             lbrk_q, lbrk_n;
	logic [POS_W-1:0] start_q, start_n;
	logic [CNT_W-1:0] tcnt_q, tcnt_n;
	logic [CNT_W-1:0] gap_q, gap_n;
	logic             bad_q, bad_n;

	logic [BYTE_W-1:0] b;
	logic              sc_mis;
	logic [IDX_W-1:0]  sc_idx;
	logic [CNT_W:0]    tsum;
	logic [CNT_W-1:0]  gap_inc;
	logic [CNT_W-1:0]  lim_eff;

	assign b = item_s1.header_byte;

	// Scheme compare for the current byte
	always_comb begin
		sc_mis = mis_q || (idx_q >= SCHEME_LEN) || (to_lower(b) != scheme_letter(idx_q));
		sc_idx = (idx_q < SCHEME_TOP) ? (idx_q + IDX_W'(1)) : idx_q;
	end

	// Saturating token arithmetic
	always_comb begin
		tsum    = {1'b0, tcnt_q} + {1'b0, gap_q} + (CNT_W+1)'(1);
		gap_inc = (gap_q + CNT_W'(1) > CNT_CAP) ? CNT_CAP : gap_q + CNT_W'(1);
	end

	// Advance the parse state by one byte
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		idx_n   = idx_q;
		mis_n   = mis_q;
		lbrk_n  = lbrk_q;
		start_n = start_q;
		tcnt_n  = tcnt_q;
		gap_n   = gap_q;
		bad_n   = bad_q;
		if (item_s1.byte_present) begin
			if (pos_q < POS_LAST) begin
				pos_n = pos_q + POS_W'(1);
			end
			case (phase_q)
				PH_LEAD: begin
					if (!is_ws(b)) begin
						mis_n   = sc_mis;
						idx_n   = sc_idx;
						phase_n = PH_SCHEME;
					end
				end
				PH_SCHEME: begin
					if (is_space_tab(b)) begin
						phase_n = PH_SEPARATED;
					end else if (is_ws(b)) begin
						lbrk_n  = 1'b1;
						phase_n = PH_SCHEME_CRLF;
					end else begin
						mis_n = sc_mis;
						idx_n = sc_idx;
					end
				end
				PH_SCHEME_CRLF: begin
					if (is_space_tab(b)) begin
						phase_n = PH_SEPARATED;
					end else if (!is_ws(b)) begin
						// Text after a line break joins the scheme, which then fails
						mis_n   = 1'b1;
						lbrk_n  = 1'b0;
						idx_n   = sc_idx;
						phase_n = PH_SCHEME;
					end
				end
				PH_SEPARATED: begin
					if (!is_ws(b)) begin
						if (lbrk_q) begin
							mis_n = 1'b1;
						end
						lbrk_n  = 1'b0;
						start_n = pos_q;
						tcnt_n  = CNT_W'(1);
						gap_n   = '0;
						bad_n   = !is_token_char(b);
						phase_n = PH_TOKEN;
					end
				end
				PH_TOKEN: begin
					if (is_ws(b)) begin
						gap_n = gap_inc;
					end else begin
						tcnt_n = (tsum > {1'b0, CNT_CAP}) ? CNT_CAP : tsum[CNT_W-1:0];
						gap_n  = '0;
						bad_n  = bad_q || (gap_q != '0) || !is_token_char(b);
					end
				end
				default: begin
					phase_n = PH_LEAD;
				end
			endcase
		end
	end

	// Result from the updated state
	assign lim_eff  = (limit > LIMIT_TOP) ? LIMIT_TOP : limit;
	assign res_fire = advance && item_s1.last_byte;

	always_comb begin
		res.status       = ST_OK;
		res.token_offset = '0;
		res.token_length = '0;
		if (phase_n == PH_LEAD) begin
			res.status = ST_EMPTY_HDR;
		end else if (phase_n != PH_TOKEN) begin
			res.status = (!mis_n && idx_n == SCHEME_LEN) ? ST_EMPTY_TOK : ST_BAD_SCHEME;
		end else if (mis_n || idx_n != SCHEME_LEN) begin
			res.status = ST_BAD_SCHEME;
		end else if (tcnt_n > lim_eff) begin
			res.status = ST_TOO_LONG;
		end else if (bad_n) begin
			res.status = ST_BAD_CHAR;
		end else begin
			res.token_offset = start_n;
			res.token_length = tcnt_n;
		end
	end

	// Hold state; clear it after the final word of a header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pos_q   <= '0;
			idx_q   <= '0;
			mis_q   <= 1'b0;
			lbrk_q  <= 1'b0;
			start_q <= '0;
			tcnt_q  <= '0;
			gap_q   <= '0;
			bad_q   <= 1'b0;
		end else if (res_fire) begin
			phase_q <= PH_LEAD;
			pos_q   <= '0;
			idx_q   <= '0;
			mis_q   <= 1'b0;
			lbrk_q  <= 1'b0;
			start_q <= '0;
			tcnt_q  <= '0;
			gap_q   <= '0;
			bad_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			idx_q   <= idx_n;
			mis_q   <= mis_n;
			lbrk_q  <= lbrk_n;
			start_q <= start_n;
			tcnt_q  <= tcnt_n;
			gap_q   <= gap_n;
			bad_q   <= bad_n;
		end
	end

	// A failed header reports neither offset nor length
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && res.status != ST_OK |-> res.token_offset == '0 && res.token_length == '0)
		else $error("failed header carries token fields");

	// An accepted token is never empty and never above the hard limit
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && res.status == ST_OK |-> res.token_length != '0 && res.token_length <= LIMIT_TOP)
		else $error("accepted token length out of range");

	// The final word leaves the parser ready for a fresh header
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> phase_q == PH_LEAD && pos_q == '0 && idx_q == '0)
		else $error("parse state not cleared after final word");

	// Token counters stay within their saturation point
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= CNT_CAP && gap_q <= CNT_CAP)
		else $error("token counter past saturation");

endmodule

### rtl/bahp_out_stage.sv
`timescale 1ns / 1ps
// Result register of the bearer header parser: holds a word until the sink takes it.
// Depends on bahp_pkg.
module bahp_out_stage import bahp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_fire,
	input  result_t res,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_fire) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load a new result word
	always_ff @(posedge clk) begin
		if (res_fire) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

### rtl/bearer_auth_header_parser.sv
`timescale 1ns / 1ps
// Top level of the bearer authorisation header parser.
// Depends on bahp_pkg, bahp_in_stage, bahp_parse_core and bahp_out_stage.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata byte, tuser present, tlast last
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata status, offset, length
//  cfg       in         cfg_valid / cfg_ready          cfg_data max token length
//
// One header byte per cycle unless a final word is held; the parse state update is a single
// pass between the input register and the result register, so the result word is registered
// when the final word moves on from the input register. Reset clears the parse state and sets
// the token limit to 4096. A result waiting on m_axis stalls s_axis only when a further
// final word reaches the input register; other words keep flowing.
module bearer_auth_header_parser import bahp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] header_byte
	input  logic                  s_axis_tuser,  // [0] byte_present
	input  logic                  s_axis_tlast,  // last_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,  // [2:0] status, [15:3] token_offset,
	                                             // [28:16] token_length, [31:29] zero
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data
);

	item_t            in_item;
	item_t            item_s1;
	logic             valid_s1;
	logic             advance;
	logic             res_fire;
	result_t          res;
	result_t          out_res;
	logic [CNT_W-1:0] limit_q;

	assign in_item.header_byte  = s_axis_tdata;
	assign in_item.byte_present = s_axis_tuser;
	assign in_item.last_byte    = s_axis_tlast;

	// Token limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Move the held word on unless it is final and the result slot stays full
	assign advance = valid_s1 && (!item_s1.last_byte || !m_axis_tvalid || m_axis_tready);

	bahp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bahp_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item_s1  (item_s1),
		.limit    (limit_q),
		.res_fire (res_fire),
		.res      (res)
	);

	bahp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_fire  (res_fire),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {3'b000, out_res.token_length, out_res.token_offset, out_res.status};

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bearer_auth_header_parser: byte stream in, one verdict per header.
// Depends on bahp_pkg and the RTL top; a scoreboard class predicts each verdict.
module tb_top;
	import bahp_pkg::*;

	localparam logic [47:0] BEARER_TEXT  = "bearer";
	localparam int          PHASE_WORDS  = 265;

	// Parser phases of the predictor
	typedef enum logic [2:0] {
		SEEK_SCHEME,
		IN_SCHEME,
		SCHEME_BREAK,
		SEEK_TOKEN,
		IN_TOKEN
	} parse_phase_t;

	typedef struct {
		status_t          status;
		logic [POS_W-1:0] offset;
		logic [CNT_W-1:0] length;
	} verdict_t;

	// Predict verdicts from accepted words and check them against result words
	class header_scoreboard;
		verdict_t         awaited[$];
		int unsigned      mismatches;
		logic [CNT_W-1:0] max_len;
		parse_phase_t     phase;
		logic [POS_W-1:0] pos;
		logic [IDX_W-1:0] letter_idx;
		bit               scheme_bad;
		bit               line_break;
		bit               bad_char;
		logic [POS_W-1:0] tok_start;
		logic [CNT_W-1:0] tok_count;
		logic [CNT_W-1:0] gap_count;

		function new();
			mismatches = 0;
			max_len = LIMIT_RST;
			restart();
		endfunction

		function void restart();
			phase = SEEK_SCHEME;
			pos = '0;
			letter_idx = '0;
			scheme_bad = 0;
			line_break = 0;
			bad_char = 0;
			tok_start = '0;
			tok_count = '0;
			gap_count = '0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function bit separator(logic [BYTE_W-1:0] b);
			return b == 8'h20 || b == 8'h09;
		endfunction

		function bit blank(logic [BYTE_W-1:0] b);
			return separator(b) || b == 8'h0D || b == 8'h0A;
		endfunction

		function bit token_char(logic [BYTE_W-1:0] b);
			if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))
				return 1;
			return b == "-" || b == "." || b == "_" || b == "~" || b == "+" || b == "/" ||
				b == "=";
		endfunction

		function logic [CNT_W-1:0] capped(int v);
			return (v > int'(CNT_CAP)) ? CNT_CAP : CNT_W'(v);
		endfunction

		// Compare one scheme letter, case folded
		function void scheme_letter_in(logic [BYTE_W-1:0] b);
			logic [BYTE_W-1:0] lc;
			lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
			if (letter_idx >= SCHEME_LEN)
				scheme_bad = 1;
			else if (lc != BEARER_TEXT[47 - 8*int'(letter_idx) -: 8])
				scheme_bad = 1;
			if (letter_idx < SCHEME_TOP)
				letter_idx++;
		endfunction

		function void take(logic [BYTE_W-1:0] b, logic [POS_W-1:0] at);
			case (phase)
				SEEK_SCHEME: begin
					if (!blank(b)) begin
						scheme_letter_in(b);
						phase = IN_SCHEME;
					end
				end
				IN_SCHEME: begin
					if (separator(b)) begin
						phase = SEEK_TOKEN;
					end else if (blank(b)) begin
						line_break = 1;
						phase = SCHEME_BREAK;
					end else begin
						scheme_letter_in(b);
					end
				end
				SCHEME_BREAK: begin
					if (separator(b)) begin
						phase = SEEK_TOKEN;
					end else if (!blank(b)) begin
						scheme_bad = 1;
						line_break = 0;
						scheme_letter_in(b);
						phase = IN_SCHEME;
					end
				end
				SEEK_TOKEN: begin
					if (!blank(b)) begin
						if (line_break)
							scheme_bad = 1;
						line_break = 0;
						tok_start = at;
						tok_count = CNT_W'(1);
						gap_count = '0;
						bad_char = !token_char(b);
						phase = IN_TOKEN;
					end
				end
				default: begin
					if (blank(b)) begin
						gap_count = capped(int'(gap_count) + 1);
					end else begin
						// whitespace inside the token spoils it
						if (gap_count != 0)
							bad_char = 1;
						tok_count = capped(int'(tok_count) + int'(gap_count) + 1);
						gap_count = '0;
						if (!token_char(b))
							bad_char = 1;
					end
				end
			endcase
		endfunction

		// Advance the parse by one accepted word; queue a verdict on the final word
		function void note_word(item_t w);
			logic [POS_W-1:0] at;
			logic [CNT_W-1:0] lim;
			verdict_t         v;
			if (w.byte_present) begin
				at = pos;
				take(w.header_byte, at);
				if (at != POS_LAST)
					pos = at + 1'b1;
			end
			if (!w.last_byte)
				return;
			lim = (max_len > LIMIT_TOP) ? LIMIT_TOP : max_len;
			v.offset = '0;
			v.length = '0;
			if (phase == SEEK_SCHEME)
				v.status = ST_EMPTY_HDR;
			else if (phase != IN_TOKEN)
				v.status = (!scheme_bad && letter_idx == SCHEME_LEN) ? ST_EMPTY_TOK :
					ST_BAD_SCHEME;
			else if (scheme_bad || letter_idx != SCHEME_LEN)
				v.status = ST_BAD_SCHEME;
			else if (tok_count > lim)
				v.status = ST_TOO_LONG;
			else if (bad_char)
				v.status = ST_BAD_CHAR;
			else begin
				v.status = ST_OK;
				v.offset = tok_start;
				v.length = tok_count;
			end
			awaited.push_back(v);
			restart();
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 50)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_word(logic [31:0] d);
			verdict_t v;
			if (awaited.size() == 0) begin
				report($sformatf("result %h with no verdict pending", d));
				return;
			end
			v = awaited.pop_front();
			if (d[2:0] !== v.status)
				report($sformatf("status %0d, want %0d", d[2:0], v.status));
			if (d[15:3] !== v.offset)
				report($sformatf("token_offset %0d, want %0d", d[15:3], v.offset));
			if (d[28:16] !== v.length)
				report($sformatf("token_length %0d, want %0d", d[28:16], v.length));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata = '0;  // [7:0] header_byte
	logic              s_axis_tuser = 1'b0; // [0] byte_present
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [31:0]       m_axis_tdata;       // [2:0] status, [15:3] offset, [28:16] length
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;

	header_scoreboard  hdr_sb = new();
	item_t             hdr[$];
	logic [CNT_W-1:0]  cur_limit = LIMIT_RST;
	bit                idle_on = 1;
	bit                stall_on = 1;
	bit                noise_on = 1;
	int                words_sent = 0;

	bearer_auth_header_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Check every accepted result word
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			hdr_sb.check_word(m_axis_tdata);
	end

	// Stall the result side in random bursts
	initial begin : result_side
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_axis_tready = 1'b0;
				hold--;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				hold = $urandom_range(0, 7);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	initial begin : watchdog
		#15_000_000;
		$display("status: fail");
		$finish;
	end

	// Header building helpers
	function automatic void put(logic [BYTE_W-1:0] b);
		item_t w;
		w.header_byte = b;
		w.byte_present = 1'b1;
		w.last_byte = 1'b0;
		hdr.push_back(w);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic item_t ignored_word();
		item_t w;
		w.header_byte = BYTE_W'($urandom_range(0, 255));
		w.byte_present = 1'b0;
		w.last_byte = 1'b0;
		return w;
	endfunction

	// Mark the end either on the final byte or with a separate empty word
	function automatic void close_header(bit marker);
		item_t w;
		if (marker || hdr.size() == 0) begin
			w = ignored_word();
			w.last_byte = 1'b1;
		end else begin
			w = hdr.pop_back();
			w.last_byte = 1'b1;
		end
		hdr.push_back(w);
	endfunction

	function automatic logic [BYTE_W-1:0] blank_byte();
		case ($urandom_range(0, 3))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0D;
			default: return 8'h0A;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] token_byte();
		string set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~+/=";
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	// Build a mostly well-formed header with random content, sometimes broken
	function automatic void make_random_header();
		int               kind;
		int               n;
		int               eff;
		logic [BYTE_W-1:0] c;
		hdr.delete();
		kind = $urandom_range(0, 99);
		eff = (cur_limit > LIMIT_TOP) ? int'(LIMIT_TOP) : int'(cur_limit);
		if (kind < 5) begin
			repeat ($urandom_range(0, 12))
				put(BYTE_W'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2))
				put(blank_byte());
			if (kind < 85) begin
				for (int i = 0; i < 6; i++) begin
					c = BEARER_TEXT[47 - 8*i -: 8];
					put($urandom_range(0, 1) ? c - 8'd32 : c);
				end
				// spoil, shorten or lengthen the scheme now and then
				if (kind >= 75) begin
					case ($urandom_range(0, 2))
						0: begin
							n = $urandom_range(0, 5);
							hdr[hdr.size() - 6 + n] = hdr[hdr.size() - 6 + n] ^ 10'h040;
						end
						1: void'(hdr.pop_back());
						default: put(token_byte());
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 8))
					put(token_byte());
			end
			if ($urandom_range(0, 7) == 0) begin
				put($urandom_range(0, 1) ? 8'h0D : 8'h0A);
				if ($urandom_range(0, 1))
					put(blank_byte());
				if ($urandom_range(0, 2) == 0)
					put(token_byte());
			end
			if ($urandom_range(0, 19) != 0) begin
				repeat ($urandom_range(1, 3))
					put($urandom_range(0, 1) ? 8'h20 : 8'h09);
			end
			if (eff <= 40 && $urandom_range(0, 2) == 0)
				n = eff + $urandom_range(0, 2) - 1;
			else
				n = $urandom_range(0, 12);
			if (n < 0)
				n = 0;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 29) == 0)
					put(BYTE_W'($urandom_range(0, 255)));
				else if ($urandom_range(0, 39) == 0)
					put(blank_byte());
				else
					put(token_byte());
			end
			repeat ($urandom_range(0, 2))
				put(blank_byte());
		end
		close_header($urandom_range(0, 3) == 0);
	endfunction

	// Drive one word and hold it until accepted
	task automatic send_word(input item_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = w.header_byte;
		s_axis_tuser = w.byte_present;
		s_axis_tlast = w.last_byte;
		do @(posedge clk); while (!s_axis_tready);
		hdr_sb.note_word(w);
		@(negedge clk);
	endtask

	task automatic send_header();
		foreach (hdr[i]) begin
			if (noise_on && $urandom_range(0, 15) == 0)
				send_word(ignored_word());
			send_word(hdr[i]);
			words_sent++;
		end
	endtask

	// Write the token limit once every verdict is out and the core has drained
	task automatic write_limit(input logic [CNT_W-1:0] v);
		s_axis_tvalid = 1'b0;
		while (hdr_sb.pending() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		hdr_sb.max_len = v;
		cur_limit = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin : stimulus
		logic [CNT_W-1:0] limits[7];
		int               start;
		limits = '{13'd1, 13'd0, 13'h1FFF, 13'd8, 13'd5000, 13'd3, LIMIT_RST};
		limits[3] = CNT_W'($urandom_range(2, 24));
		limits[4] = CNT_W'($urandom_range(4097, 8190));
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty header, clean token around an ignored word,
		// line break in the scheme, extreme byte values
		hdr.delete();
		close_header(1);
		send_header();
		hdr.delete();
		put_text("\tbEARER ");
		hdr.push_back(ignored_word());
		put_text("~\n");
		close_header(0);
		send_header();
		hdr.delete();
		put_text("bearer\r a");
		close_header(0);
		send_header();
		hdr.delete();
		put(8'h00);
		put(8'hFF);
		close_header(1);
		send_header();

		// Long headers: largest token, saturated counters and position
		write_limit(LIMIT_RST);
		hdr.delete();
		put_text("bearer ");
		repeat (4096) put(token_byte());
		close_header(0);
		send_header();
		hdr.delete();
		put_text("Bearer ");
		repeat (4100) put(token_byte());
		close_header(1);
		send_header();
		hdr.delete();
		repeat (8195) put(blank_byte());
		put_text("bearer z");
		close_header(0);
		send_header();
		hdr.delete();
		put_text("bearer a");
		repeat (4100) put(8'h20);
		put_text("b");
		close_header(0);
		send_header();

		// Random headers under a range of limits; the last phase runs flat out
		for (int ph = 0; ph < 7; ph++) begin
			write_limit(limits[ph]);
			if (ph == 6) begin
				idle_on = 0;
				stall_on = 0;
			end
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				if (ph < 6)
					idle_on = ($urandom_range(0, 9) < 7);
				make_random_header();
				send_header();
			end
		end

		s_axis_tvalid = 1'b0;
		while (hdr_sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (hdr_sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
